### sv/ffea_pkg.sv
// shared constants and codes for the first-fit extent allocator
package ffea_pkg;
    localparam int unsigned DEF_MAX_EXTENTS = 64;
    localparam int unsigned DEF_OFFSET_BITS = 32;
    localparam int unsigned FIELD_W         = 32;
    localparam int unsigned STATUS_W        = 3;
    localparam int unsigned REQ_W           = 2;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req REQ_ALLOC = 2'd0;
    localparam t_req REQ_FREE  = 2'd1;
    localparam t_req REQ_CLEAR = 2'd2;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_NOFIT = 3'd1;
    localparam t_status ST_FULL  = 3'd2;
    localparam t_status ST_BAD   = 3'd3;
    localparam t_status ST_ZERO  = 3'd4;

    localparam logic [FIELD_W-1:0] REGION_RESET = 32'd65536;
endpackage

### sv/ffea_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ffea_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/first_fit_extent_allocator.sv
// first-fit extent allocator top level: sequencer over the extent table memories
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  req     | i_valid/o_ready, i_req_type, i_block_size/offset| in
//  rsp     | o_valid/i_ready, o_status, o_alloc_offset, ...  | out
//  cfg     | i_cfg_we, i_cfg_data (region_size)              | in
//
// one request at a time; a request walks the table one entry a cycle through
// the memory read port, then shifts entries up or down one at a time through
// a read state and a write state. reset restores one extent covering the
// region at once; no clearing pass. the result waits in an output register,
// and a new request is taken only after the previous result is transferred.
module first_fit_extent_allocator
    import ffea_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [FIELD_W-1:0]       i_block_size,
    input  logic [FIELD_W-1:0]       i_block_offset,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [FIELD_W-1:0]       o_alloc_offset,
    output logic [FIELD_W-1:0]       o_free_total,
    input  logic                     i_cfg_we,
    input  logic [FIELD_W-1:0]       i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam int unsigned OW = OFFSET_BITS;
    localparam int unsigned XW = OW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]          r_state;
    logic [FIELD_W-1:0]  r_region;
    logic [CW-1:0]       r_count;
    logic [OW-1:0]       r_free_sum;
    t_req                r_req;
    logic [OW-1:0]       r_size, r_off;
    logic [CW-1:0]       r_idx;      // entry whose read data arrives this cycle
    logic [OW-1:0]       r_prev_off, r_prev_size;
    logic [CW-1:0]       r_pos;      // shift cursor
    logic                r_shift_up; // insert shifts up, remove shifts down
    logic [CW-1:0]       r_shift_end;
    logic [OW-1:0]       r_sh_off, r_sh_size;
    t_status             r_status;
    logic [FIELD_W-1:0]  r_granted;
    logic                r_valid;

    // memory ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [OW-1:0] wd_off, wd_size, rd_off, rd_size;

    ffea_ram #(.WIDTH(OW), .DEPTH(MAX_EXTENTS)) u_off_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wd_off),
        .i_raddr(raddr), .o_rdata(rd_off)
    );
    ffea_ram #(.WIDTH(OW), .DEPTH(MAX_EXTENTS)) u_size_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wd_size),
        .i_raddr(raddr), .o_rdata(rd_size)
    );

    logic [OW-1:0] in_size, in_off, region_m;
    assign in_size  = i_block_size[OW-1:0];
    assign in_off   = i_block_offset[OW-1:0];
    assign region_m = r_region[OW-1:0];

    // free-path compares against current and previous entries
    logic [XW-1:0] fr_end, prev_end;
    assign fr_end   = {1'b0, r_off} + {1'b0, r_size};
    assign prev_end = {1'b0, r_prev_off} + {1'b0, r_prev_size};

    logic [CW-1:0] n_idx_inc;
    assign n_idx_inc = r_idx + CW'(1);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_alloc_offset = r_granted;
    assign o_free_total   = FIELD_W'(r_free_sum);

    // combinational memory control
    always_comb begin
        we      = 1'b0;
        waddr   = '0;
        wd_off  = r_sh_off;
        wd_size = r_sh_size;
        raddr   = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (i_valid && i_req_type == REQ_CLEAR) begin
                    we      = 1'b1;
                    wd_off  = '0;
                    wd_size = region_m;
                end
            end
            S_SCAN: begin
                raddr = n_idx_inc[AW-1:0];
                // a free that stops here keeps the current entry on the read port
                if (r_req != REQ_ALLOC && !(r_idx < r_count && rd_off < r_off)) begin
                    raddr = r_idx[AW-1:0];
                end
            end
            S_RD:    raddr = r_pos[AW-1:0];
            S_WR: begin
                we    = 1'b1;
                waddr = r_shift_up ? AW'(r_pos + CW'(1)) : AW'(r_pos - CW'(1));
                wd_off  = rd_off;
                wd_size = rd_size;
            end
            S_DONE: begin
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
            end
            default: ;
        endcase
        // reset loads the single extent covering the region
        if (!i_rst_n) begin
            we      = 1'b1;
            waddr   = '0;
            wd_off  = '0;
            wd_size = OW'(REGION_RESET);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_region   <= REGION_RESET;
            r_count    <= CW'(1);
            r_free_sum <= OW'(REGION_RESET);
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req      <= i_req_type;
                        r_size     <= in_size;
                        r_off      <= in_off;
                        r_idx      <= '0;
                        r_granted  <= '0;
                        r_status   <= ST_OK;
                        r_state    <= S_RESP;
                        r_valid    <= 1'b1;
                        if (i_req_type == REQ_CLEAR) begin
                            r_count    <= CW'(1);
                            r_free_sum <= region_m;
                        end else if (i_req_type == REQ_ALLOC || i_req_type == REQ_FREE) begin
                            if (in_size == '0) begin
                                r_status <= ST_ZERO;
                            end else if (i_req_type == REQ_FREE &&
                                         ({1'b0, in_off} + {1'b0, in_size}) > {1'b0, region_m}) begin
                                r_status <= ST_BAD;
                            end else begin
                                r_valid <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_status <= ST_BAD;
                        end
                    end
                end
                S_SCAN: begin
                    // entry r_idx on the read port when r_idx < count
                    if (r_req == REQ_ALLOC) begin
                        if (r_idx >= r_count) begin
                            r_status <= ST_NOFIT;
                            r_state  <= S_RESP;
                            r_valid  <= 1'b1;
                        end else if (rd_size >= r_size) begin
                            r_granted  <= FIELD_W'(rd_off);
                            r_free_sum <= r_free_sum - r_size;
                            if (rd_size == r_size) begin
                                r_shift_up  <= 1'b0;
                                r_pos       <= n_idx_inc;
                                r_shift_end <= r_count;
                                r_count     <= r_count - CW'(1);
                                r_state     <= (n_idx_inc < r_count) ? S_RD : S_RESP;
                                r_valid     <= !(n_idx_inc < r_count);
                            end else begin
                                r_sh_off  <= rd_off + r_size;
                                r_sh_size <= rd_size - r_size;
                                r_state   <= S_DONE;
                            end
                        end else begin
                            r_idx <= n_idx_inc;
                        end
                    end else begin
                        if (r_idx < r_count && rd_off < r_off) begin
                            r_prev_off  <= rd_off;
                            r_prev_size <= rd_size;
                            r_idx       <= n_idx_inc;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    // read port still holds entry r_idx (address unchanged)
                    logic has_prev, has_next, jp, jn;
                    has_prev = (r_idx != '0);
                    has_next = (r_idx < r_count);
                    jp = has_prev && (prev_end == {1'b0, r_off});
                    jn = has_next && (fr_end == {1'b0, rd_off});
                    if ((has_next && rd_off == r_off) ||
                        (has_prev && prev_end > {1'b0, r_off}) ||
                        (has_next && fr_end > {1'b0, rd_off})) begin
                        r_status <= ST_BAD;
                        r_state  <= S_RESP;
                        r_valid  <= 1'b1;
                    end else if (jp && jn) begin
                        r_sh_off    <= r_prev_off;
                        r_sh_size   <= r_prev_size + r_size + rd_size;
                        r_idx       <= r_idx - CW'(1);
                        r_free_sum  <= r_free_sum + r_size;
                        r_shift_up  <= 1'b0;
                        r_pos       <= n_idx_inc;
                        r_shift_end <= r_count;
                        r_count     <= r_count - CW'(1);
                        r_state     <= S_DONE;
                    end else if (jp) begin
                        r_sh_off    <= r_prev_off;
                        r_sh_size   <= r_prev_size + r_size;
                        r_idx       <= r_idx - CW'(1);
                        r_free_sum  <= r_free_sum + r_size;
                        r_shift_end <= '0;
                        r_state     <= S_DONE;
                    end else if (jn) begin
                        r_sh_off    <= r_off;
                        r_sh_size   <= rd_size + r_size;
                        r_free_sum  <= r_free_sum + r_size;
                        r_shift_end <= '0;
                        r_state     <= S_DONE;
                    end else if (r_count >= MAXC) begin
                        r_status <= ST_FULL;
                        r_state  <= S_RESP;
                        r_valid  <= 1'b1;
                    end else begin
                        r_sh_off    <= r_off;
                        r_sh_size   <= r_size;
                        r_free_sum  <= r_free_sum + r_size;
                        r_shift_up  <= 1'b1;
                        r_pos       <= r_count - CW'(1);
                        r_shift_end <= r_idx;
                        r_count     <= r_count + CW'(1);
                        r_state     <= (r_count > r_idx) ? S_RD : S_DONE;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    // move one entry, then step the cursor
                    if (r_shift_up) begin
                        if (r_pos == r_shift_end) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pos   <= r_pos - CW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        if (r_pos + CW'(1) >= r_shift_end) begin
                            r_state <= S_RESP;
                            r_valid <= 1'b1;
                        end else begin
                            r_pos   <= r_pos + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    // entry write done; a merge of both neighbours then closes the gap
                    if (!r_shift_up && r_req == REQ_FREE && r_pos < r_shift_end &&
                        r_pos == r_idx + CW'(2)) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_RESP;
                        r_valid <= 1'b1;
                    end
                end
                S_RESP: begin
                    if (r_valid && i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### tb/tb.sv
// testbench for the first-fit extent allocator: directed and random request streams
`timescale 1ns / 1ps

module tb;
    import ffea_pkg::*;

    localparam int unsigned NUM_EXTENTS = DEF_MAX_EXTENTS;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] alloc_offset;
        logic [FIELD_W-1:0] free_total;
    } t_grant;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [REQ_W-1:0]   i_req_type = REQ_ALLOC;
    logic [FIELD_W-1:0] i_block_size = '0;
    logic [FIELD_W-1:0] i_block_offset = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [FIELD_W-1:0] o_alloc_offset;
    logic [FIELD_W-1:0] o_free_total;
    logic               i_cfg_we = 1'b0;
    logic [FIELD_W-1:0] i_cfg_data = '0;

    // predictor copy of the extent table
    logic [FIELD_W-1:0] region_bytes;
    logic [FIELD_W-1:0] ext_off [NUM_EXTENTS];
    logic [FIELD_W-1:0] ext_len [NUM_EXTENTS];
    int unsigned        ext_count;
    logic [FIELD_W-1:0] free_bytes;

    t_grant             pending_grants[$];
    int unsigned        error_count = 0;
    longint unsigned    cycle_count = 0;
    bit                 rx_hold = 1'b0;
    bit                 rx_quiet = 1'b0;
    int unsigned        rx_stall = 0;

    first_fit_extent_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_block_size   (i_block_size),
        .i_block_offset (i_block_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset),
        .o_free_total   (o_free_total),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_extent_allocator verification failed");
            $finish;
        end
    end

    function automatic int unsigned short_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic void rebuild_extents();
        ext_off[0] = '0;
        ext_len[0] = region_bytes;
        ext_count = 1;
        free_bytes = region_bytes;
    endfunction

    function automatic void drop_extent(int unsigned idx);
        for (int unsigned k = idx; k + 1 < ext_count; k++) begin
            ext_off[k] = ext_off[k+1];
            ext_len[k] = ext_len[k+1];
        end
        ext_count--;
    endfunction

    // compute the expected grant and update the table
    function automatic t_grant predict_grant(t_req req, logic [FIELD_W-1:0] len,
                                             logic [FIELD_W-1:0] off);
        t_grant g;
        int unsigned i;
        logic [FIELD_W:0] tail;
        bit has_prev, has_next, join_prev, join_next;
        g = '0;
        g.status = ST_OK;
        i = 0;
        tail = {1'b0, off} + {1'b0, len};
        case (req)
            REQ_ALLOC: begin
                if (len == 0) begin
                    g.status = ST_ZERO;
                end else begin
                    g.status = ST_NOFIT;
                    for (i = 0; i < ext_count; i++) begin
                        if (ext_len[i] >= len) begin
                            g.status = ST_OK;
                            g.alloc_offset = ext_off[i];
                            if (ext_len[i] == len) begin
                                drop_extent(i);
                            end else begin
                                ext_off[i] += len;
                                ext_len[i] -= len;
                            end
                            free_bytes -= len;
                            break;
                        end
                    end
                end
            end
            REQ_FREE: begin
                if (len == 0) begin
                    g.status = ST_ZERO;
                end else if (tail > {1'b0, region_bytes}) begin
                    g.status = ST_BAD;
                end else begin
                    while (i < ext_count && ext_off[i] < off)
                        i++;
                    has_prev = (i > 0);
                    has_next = (i < ext_count);
                    join_prev = 1'b0;
                    join_next = 1'b0;
                    if (has_next && ext_off[i] == off)
                        g.status = ST_BAD;
                    else if (has_prev && ({1'b0, ext_off[i-1]} + ext_len[i-1]) > off)
                        g.status = ST_BAD;
                    else if (has_next && tail > {1'b0, ext_off[i]})
                        g.status = ST_BAD;
                    if (g.status == ST_OK) begin
                        join_prev = has_prev && ((ext_off[i-1] + ext_len[i-1]) == off);
                        join_next = has_next && (tail == {1'b0, ext_off[i]});
                        if (join_prev && join_next) begin
                            ext_len[i-1] += len + ext_len[i];
                            drop_extent(i);
                        end else if (join_prev) begin
                            ext_len[i-1] += len;
                        end else if (join_next) begin
                            ext_off[i] = off;
                            ext_len[i] += len;
                        end else if (ext_count >= NUM_EXTENTS) begin
                            g.status = ST_FULL;
                        end else begin
                            for (int unsigned k = ext_count; k > i; k--) begin
                                ext_off[k] = ext_off[k-1];
                                ext_len[k] = ext_len[k-1];
                            end
                            ext_off[i] = off;
                            ext_len[i] = len;
                            ext_count++;
                        end
                        if (g.status == ST_OK)
                            free_bytes += len;
                    end
                end
            end
            REQ_CLEAR: rebuild_extents();
            default: g.status = ST_BAD;
        endcase
        g.free_total = free_bytes;
        return g;
    endfunction

    // send one request and queue its expected grant
    task automatic send_request(t_req req, logic [FIELD_W-1:0] len,
                                logic [FIELD_W-1:0] off);
        int unsigned gap;
        gap = short_gap();
        repeat (gap + 1) @(posedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_block_size <= len;
        i_block_offset <= off;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_grants.push_back(predict_grant(req, len, off));
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_region(logic [FIELD_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        region_bytes = value;
    endtask

    // receiver ready with random stalls, now and then a long one
    always @(posedge i_clk) begin
        if (rx_hold || !i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_quiet) begin
            i_ready <= 1'b1;
        end else if (rx_stall != 0) begin
            i_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 39) == 0)
                rx_stall <= $urandom_range(20, 200);
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0h total=%0h",
                         $time, o_status, o_alloc_offset, o_free_total);
                error_count++;
            end else begin
                exp_g = pending_grants.pop_front();
                if (o_status !== exp_g.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_g.status, o_status);
                    error_count++;
                end
                if (o_alloc_offset !== exp_g.alloc_offset) begin
                    $display("%0t: alloc_offset expected %0h actual %0h",
                             $time, exp_g.alloc_offset, o_alloc_offset);
                    error_count++;
                end
                if (o_free_total !== exp_g.free_total) begin
                    $display("%0t: free_total expected %0h actual %0h",
                             $time, exp_g.free_total, o_free_total);
                    error_count++;
                end
            end
        end
    end

    // random free of a plausible block near the table
    task automatic random_free();
        logic [FIELD_W-1:0] off, len;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            off = $urandom_range(0, 255) * 64;
            len = $urandom_range(1, 16) * 64;
        end else if (pick < 9) begin
            off = $urandom_range(0, 65535);
            len = $urandom_range(0, 2048);
        end else begin
            off = $urandom;
            len = $urandom;
        end
        send_request(REQ_FREE, len, off);
    endtask

    task automatic random_alloc();
        logic [FIELD_W-1:0] len;
        case ($urandom_range(0, 9))
            0: len = $urandom;
            1: len = 0;
            default: len = $urandom_range(1, 16) * 64;
        endcase
        send_request(REQ_ALLOC, len, $urandom);
    endtask

    task automatic test_directed();
        send_request(REQ_ALLOC, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd100, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_ALLOC, 32'd200, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd10);
        send_request(REQ_FREE, 32'd50, 32'd0);
        send_request(REQ_FREE, 32'd50, 32'd100);
        send_request(REQ_FREE, 32'd60, 32'd40);
        send_request(REQ_FREE, 32'd10, 32'd290);
        send_request(REQ_FREE, 32'd10, 32'd300);
        send_request(REQ_FREE, 32'd100, 32'd65500);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'd40, 32'd0);
        send_request(REQ_FREE, 32'd10, 32'd100);
        send_request(REQ_FREE, 32'd90, 32'd110);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'd65536, 32'd0);
        send_request(REQ_FREE, 32'd16, 32'd1000);
        send_request(REQ_FREE, 32'd24, 32'd2000);
        send_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // fragment the table until it is full, then free an isolated block
    task automatic test_table_full();
        write_region(32'd65536);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd65536, 32'd0);
        for (int unsigned k = 0; k < NUM_EXTENTS + 2; k++)
            send_request(REQ_FREE, 32'd8, k * 32);
        send_request(REQ_FREE, 32'd8, 32'd40000);
        send_request(REQ_FREE, 32'd8, 32'd8);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
    endtask

    task automatic test_region_extremes();
        write_region(32'd1);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_FREE, 32'd1, 32'd1);
        send_request(REQ_FREE, 32'd1, 32'd0);
        write_region(32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'h8000_0000, 32'd0);
        send_request(REQ_FREE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'd0);
    endtask

    // receiver stalls long while requests keep coming
    task automatic test_backpressure();
        write_region(32'd65536);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int unsigned k = 0; k < 8; k++)
                random_alloc();
        join
        wait_drained();
    endtask

    task automatic test_random();
        logic [FIELD_W-1:0] sizes[4] = '{32'd4096, 32'd65536, 32'd16384, 32'd65536};
        for (int unsigned p = 0; p < 4; p++) begin
            write_region(sizes[p]);
            rx_quiet = (p == 2);
            send_request(REQ_CLEAR, 32'd0, 32'd0);
            for (int unsigned k = 0; k < 210; k++) begin
                case ($urandom_range(0, 19))
                    0: send_request(REQ_CLEAR, $urandom, $urandom);
                    1: send_request(2'd3, $urandom, $urandom);
                    default:
                        if ($urandom_range(0, 1)) random_alloc();
                        else random_free();
                endcase
            end
        end
        rx_quiet = 1'b0;
    endtask

    initial begin
        region_bytes = REGION_RESET;
        rebuild_extents();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_region_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (error_count == 0 && pending_grants.size() == 0)
            $display("first_fit_extent_allocator verification clean");
        else
            $display("first_fit_extent_allocator verification failed");
        $finish;
    end
endmodule
